FILE: hdl/swtf_pkg.sv
// Package for the stereo waveshaper with tone filter.
// Holds register indexes, shaper modes, datapath operation codes and the
// control/status structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swtf_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVELS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN   = 3'd4;

  localparam logic [1:0] MODE_SOFT  = 2'd0;
  localparam logic [1:0] MODE_HARD  = 2'd1;
  localparam logic [1:0] MODE_FOLD  = 2'd2;
  localparam logic [1:0] MODE_CRUSH = 2'd3;

  localparam logic [13:0] DRIVE_RESET  = 14'd256;
  localparam logic [6:0]  LEVELS_RESET = 7'd64;
  localparam logic [15:0] COEF_RESET   = 16'd32768;
  localparam logic [15:0] GAIN_RESET   = 16'd4096;

  typedef struct packed {
    logic [1:0]  mode;
    logic [13:0] drive;
    logic [6:0]  levels;
    logic [15:0] coef;
    logic [15:0] gain;
  } swtf_cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DRIVE,
    OP_SQUARE,
    OP_CUBE,
    OP_SHAPE,
    OP_QUANT,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_CRUSH,
    OP_FILTER,
    OP_GAIN,
    OP_PUBLISH
  } swtf_op_t;

  typedef struct packed {
    swtf_op_t op;
    logic     ch;
  } swtf_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic [1:0] mode;
  } swtf_status_t;

endpackage
`default_nettype wire

FILE: hdl/swtf_in_if.sv
// Input sample-pair channel: valid/ready plus the left and right samples.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface swtf_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

FILE: hdl/swtf_out_if.sv
// Output sample-pair channel: valid/ready plus the left and right results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface swtf_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

FILE: hdl/swtf_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on swtf_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface swtf_cfg_if
  import swtf_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/swtf_datapath.sv
// Datapath: shared signed multiplier, restoring divider, filter levels and
// result registers, driven one operation per cycle. Depends on swtf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swtf_datapath
  import swtf_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire swtf_cmd_t                     cmd,
  input  wire swtf_cfg_t                     cfg,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  output swtf_status_t                       status,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out
);

  localparam int N  = SAMPLE_BITS;
  localparam int MW = N + 2;
  localparam int WW = 2 * MW;
  localparam int DW = N + 7;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [WW-1:0] UNIT_W = WW'(1) <<< (N - 1);
  localparam logic signed [WW-1:0] HALF_W = WW'(1) <<< (N - 2);

  function automatic logic signed [N:0] clamp_unit(input logic signed [WW-1:0] v);
    logic signed [N:0] r;
    if (v > UNIT_W) r = (N+1)'(UNIT_W);
    else if (v < -UNIT_W) r = (N+1)'(-UNIT_W);
    else r = (N+1)'(v);
    return r;
  endfunction

  logic signed [N-1:0]  x_l, x_r, x;
  logic signed [N+7:0]  y;
  logic [N-1:0]         c2;
  logic signed [N+1:0]  shaped;
  logic [6:0]           q;
  logic [6:0]           rem;
  logic [DW-1:0]        num, quo;
  logic [CW-1:0]        div_cnt;
  logic signed [N:0]    lvl [0:1];
  logic signed [N-1:0]  res [0:1];

  logic [13:0]          drive_eff;
  logic [6:0]           lv_eff;
  logic signed [WW-1:0] yw, ycw, prod;
  logic signed [N:0]    yc, xe, ax, lvl_sel;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [WW-1:0] c3w, cube_w, u2, dw_fold, dabs, fold_w, magw;
  logic [N:0]           fold_m;
  logic [7:0]           rs;
  logic signed [WW-1:0] stepw, ow;

  assign x         = cmd.ch ? x_r : x_l;
  assign drive_eff = (cfg.drive < DRIVE_RESET) ? DRIVE_RESET : cfg.drive;
  assign lv_eff    = (cfg.levels == 7'd0) ? 7'd1 : cfg.levels;
  assign yw        = WW'(y);
  assign yc        = clamp_unit(yw);
  assign ycw       = WW'(yc);
  assign xe        = (N+1)'(x);
  assign ax        = xe[N] ? -xe : xe;
  assign lvl_sel   = lvl[cmd.ch];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DRIVE: begin
        mul_a = MW'(x);
        mul_b = MW'($signed({1'b0, drive_eff}));
      end
      OP_SQUARE: begin
        mul_a = MW'(yc);
        mul_b = MW'(yc);
      end
      OP_CUBE: begin
        mul_a = MW'($signed({1'b0, c2}));
        mul_b = MW'(yc);
      end
      OP_QUANT: begin
        mul_a = MW'(ax);
        mul_b = MW'($signed({1'b0, lv_eff}));
      end
      OP_FILTER: begin
        mul_a = MW'(shaped) - MW'(lvl_sel);
        mul_b = MW'($signed({1'b0, cfg.coef}));
      end
      OP_GAIN: begin
        mul_a = MW'(lvl_sel);
        mul_b = MW'($signed({1'b0, cfg.gain}));
      end
      default: ;
    endcase
  end

  assign prod = WW'(mul_a) * WW'(mul_b);

  // cubic soft clip: (3c - c^3) / 2
  assign c3w    = prod >>> (N - 1);
  assign cube_w = ((ycw <<< 1) + ycw - c3w) >>> 1;

  // triangle fold: wrap (y + 3) into one period of four, mirror about zero
  assign u2      = yw + (UNIT_W <<< 1) + UNIT_W;
  assign fold_m  = u2[N:0];
  assign dw_fold = WW'($signed({1'b0, fold_m})) - (UNIT_W <<< 1);
  assign dabs    = dw_fold[WW-1] ? -dw_fold : dw_fold;
  assign fold_w  = dabs - UNIT_W;

  assign magw  = WW'($signed({1'b0, quo[N-1:0]}));
  assign rs    = {rem, num[DW-1]};
  assign stepw = (prod + WW'(32768)) >>> 16;
  assign ow    = (prod + WW'(2048)) >>> 12;

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl[0] <= '0;
      lvl[1] <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          x_l <= left_in;
          x_r <= right_in;
        end
        OP_DRIVE:  y  <= (N+8)'(prod >>> 8);
        OP_SQUARE: c2 <= prod[2*N-2:N-1];
        OP_CUBE:   shaped <= (N+2)'(cube_w);
        OP_SHAPE:  shaped <= (cfg.mode == MODE_HARD) ? (N+2)'(ycw) : (N+2)'(fold_w);
        OP_QUANT:  q <= 7'((prod + HALF_W) >>> (N - 1));
        OP_DIV_START: begin
          num     <= (DW'(q) << (N - 1)) + DW'(lv_eff >> 1);
          quo     <= '0;
          rem     <= '0;
          div_cnt <= '0;
        end
        OP_DIV_STEP: begin
          if (rs >= {1'b0, lv_eff}) begin
            rem <= 7'(rs - {1'b0, lv_eff});
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= rs[6:0];
            quo <= {quo[DW-2:0], 1'b0};
          end
          num     <= num << 1;
          div_cnt <= div_cnt + CW'(1);
        end
        OP_CRUSH: shaped <= x[N-1] ? (N+2)'(-magw) : (N+2)'(magw);
        OP_FILTER: lvl[cmd.ch] <= clamp_unit(WW'(lvl_sel) + stepw);
        OP_GAIN: begin
          if (ow > UNIT_W - WW'(1)) res[cmd.ch] <= N'(UNIT_W - WW'(1));
          else if (ow < -UNIT_W) res[cmd.ch] <= N'(-UNIT_W);
          else res[cmd.ch] <= N'(ow);
        end
        OP_PUBLISH: begin
          left_out  <= res[0];
          right_out <= res[1];
        end
        default: ;
      endcase
    end
  end

  assign status.div_done = (div_cnt == CW'(DW));
  assign status.mode     = cfg.mode;

endmodule
`default_nettype wire

FILE: hdl/swtf_ctrl.sv
// Controller: sequences the datapath through both channels of a sample pair
// and runs the input and output handshakes. Depends on swtf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swtf_ctrl
  import swtf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire swtf_status_t status,
  output swtf_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DRIVE, S_SQUARE, S_CUBE, S_SHAPE, S_QUANT, S_DIV_START,
    S_DIV, S_CRUSH, S_FILTER, S_GAIN, S_DONE
  } state_t;

  state_t state;
  logic   ch;
  logic   publish;

  assign in_ready = (state == S_IDLE);
  assign publish  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    cmd.ch = ch;
    case (state)
      S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_DRIVE:     cmd.op = OP_DRIVE;
      S_SQUARE:    cmd.op = OP_SQUARE;
      S_CUBE:      cmd.op = OP_CUBE;
      S_SHAPE:     cmd.op = OP_SHAPE;
      S_QUANT:     cmd.op = OP_QUANT;
      S_DIV_START: cmd.op = OP_DIV_START;
      S_DIV:       cmd.op = status.div_done ? OP_NONE : OP_DIV_STEP;
      S_CRUSH:     cmd.op = OP_CRUSH;
      S_FILTER:    cmd.op = OP_FILTER;
      S_GAIN:      cmd.op = OP_GAIN;
      S_DONE:      cmd.op = publish ? OP_PUBLISH : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !publish) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch    <= 1'b0;
            state <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          case (status.mode) inside
            MODE_SOFT:            state <= S_SQUARE;
            MODE_HARD, MODE_FOLD: state <= S_SHAPE;
            default:              state <= S_QUANT;
          endcase
        end
        S_SQUARE:    state <= S_CUBE;
        S_CUBE:      state <= S_FILTER;
        S_SHAPE:     state <= S_FILTER;
        S_QUANT:     state <= S_DIV_START;
        S_DIV_START: state <= S_DIV;
        S_DIV:       if (status.div_done) state <= S_CRUSH;
        S_CRUSH:     state <= S_FILTER;
        S_FILTER:    state <= S_GAIN;
        S_GAIN: begin
          if (ch) begin
            state <= S_DONE;
          end else begin
            ch    <= 1'b1;
            state <= S_DRIVE;
          end
        end
        S_DONE: begin
          if (publish) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    publish |=> out_valid) else $error("published pair not marked valid");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DRIVE && !ch))
    else $error("accepted pair did not start on the left channel");
  a_right_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_GAIN && ch) |=> (state == S_DONE))
    else $error("right channel gain did not finish the pair");
`endif

endmodule
`default_nettype wire

FILE: hdl/stereo_waveshaper_tone_filter.sv
// Top level of the stereo waveshaper with tone filter.
// Depends on swtf_pkg, the three channel interfaces, swtf_ctrl and swtf_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted beat carries a left/right pair; each channel is driven, shaped
// (soft clip, hard clip, fold or level crush), smoothed by its own one-pole
// lowpass, gained and saturated, and one result beat is returned per input
// beat. All arithmetic runs through one shared multiplier, one operation a
// cycle, left channel first. In soft clip each channel steps through drive,
// square, cube, filter and gain; hard clip and fold step through drive,
// shape, filter and gain; crush steps through drive, quantise, the restoring
// divider, crush, filter and gain. One pair is processed at a time; the
// finished pair sits in the output register, so the next pair is accepted
// while it waits. Configuration writes are always accepted and must be made
// only while the block is idle.
module stereo_waveshaper_tone_filter
  import swtf_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic   clk,
  input  wire logic   rst,
  swtf_in_if.sink     sample_in,
  swtf_out_if.source  sample_out,
  swtf_cfg_if.sink    cfg
);

  swtf_cfg_t    cfg_regs;
  swtf_cmd_t    cmd;
  swtf_status_t status;

  // Register file: hold the settings; out-of-range indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.mode   <= MODE_SOFT;
      cfg_regs.drive  <= DRIVE_RESET;
      cfg_regs.levels <= LEVELS_RESET;
      cfg_regs.coef   <= COEF_RESET;
      cfg_regs.gain   <= GAIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODE:   cfg_regs.mode   <= cfg.data[1:0];
        REG_DRIVE:  cfg_regs.drive  <= cfg.data[13:0];
        REG_LEVELS: cfg_regs.levels <= cfg.data[6:0];
        REG_COEF:   cfg_regs.coef   <= cfg.data;
        REG_GAIN:   cfg_regs.gain   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer: walk both channels through the datapath, one beat at a time.
  swtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (sample_out.valid),
    .out_ready (sample_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, filter state and output register.
  swtf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg_regs),
    .left_in   (sample_in.left_in),
    .right_in  (sample_in.right_in),
    .status    (status),
    .left_out  (sample_out.left_out),
    .right_out (sample_out.right_out)
  );

endmodule
`default_nettype wire
